// ===== design/rfc_pkg.sv =====
`timescale 1ns / 1ps
package rfc_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned TAP_COUNT_W = 7;
  localparam int unsigned ROW_COUNT_W = 7;
  localparam int unsigned ROUND_SHIFT = 15;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd1;
  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_MAX = 7'd127;

  // input item codes
  localparam logic OP_TAP_WRITE = 1'b0;
  localparam logic OP_SAMPLE    = 1'b1;

  // register file: paddr bit REG_SEL_BIT selects the register
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam int unsigned REG_SEL_BIT   = 2;
  localparam logic        REG_TAP_COUNT = 1'b0;

  typedef struct packed {
    logic                       op;
    logic [5:0]                 tap_index;
    logic signed [SAMPLE_W-1:0] tap_value;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       row_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic hist_shift;
    logic hist_clear;
    logic scan_load;
    logic scan_shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic acc_clear;
    logic mul_en;
  } mac_ctrl_t;

endpackage

// ===== design/row_fir_same_convolution_unit.sv =====
`timescale 1ns / 1ps
// Same-length row FIR filter. A kernel of up to MAX_TAPS Q1.15 taps is loaded one tap per
// transaction (op 0) and tap_count (APB, address 0) selects how many are in use. Row samples
// (op 1) enter a chain of MAX_TAPS cells, each holding one tap and one history sample. A result
// is formed by copying the chain into a scan path and walking it past a single shared
// multiply-accumulate unit at the head, one tap per cycle, so a sample that yields a result
// passes through accept, load, one multiply per tap in use (n), sum and emit; a tap load, and
// a non-last sample that yields nothing, leave the engine idle and ready. On the last sample
// of a row each further flushed result takes one zero shift, then load, multiply, sum, emit;
// a last sample that arrives while the row is still shorter than the centre offset s = (n-1)/2
// takes its accept cycle and then s-t zero shifts (t samples already in the row) before its
// first flushed result is formed. Results are rounded half up and saturated to 16 bits; one
// finished result waits in the output register while the next transaction is taken, and the
// engine stalls only when a second result is ready before the first is taken.
module row_fir_same_convolution_unit import rfc_pkg::*; #(
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned N_W   = $clog2(MAX_TAPS + 1);
  localparam int unsigned ACC_W = 2 * SAMPLE_W + IDX_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [TAP_COUNT_W-1:0] tap_count_q;
  logic [ROW_COUNT_W-1:0] row_cnt_q;
  logic [N_W-1:0]         n_q, s_q, e_q, first_q, cnt_q;
  logic                   last_q;
  logic                   out_valid_q;
  out_item_t              out_data_q;

  logic                   in_acc, tap_acc, smp_acc;
  logic                   cfg_we;
  logic [N_W-1:0]         n_use, s_use, first_use, e_nxt;
  logic                   emit_now;
  logic                   out_free, emit_fire, row_done;
  logic signed [SAMPLE_W-1:0] mac_value;

  cell_ctrl_t             cell_ctrl;
  mac_ctrl_t              mac_ctrl;
  logic [MAX_TAPS-1:0]    tap_we;
  logic [SAMPLE_W-1:0]    hist_w [MAX_TAPS+1];
  logic [SAMPLE_W-1:0]    stap_w [MAX_TAPS+1];
  logic [SAMPLE_W-1:0]    ssmp_w [MAX_TAPS+1];

  // handshakes
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign tap_acc    = in_acc & (in_data_i.op == OP_TAP_WRITE);
  assign smp_acc    = in_acc & (in_data_i.op == OP_SAMPLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_fire  = (state_q == ST_EMIT) && out_free;
  assign row_done   = emit_fire && last_q && (e_q == s_q);

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  always_comb begin
    if (psel && (paddr[REG_SEL_BIT] == REG_TAP_COUNT)) begin
      prdata = PDATA_W'(tap_count_q);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
    end else if (cfg_we && (paddr[REG_SEL_BIT] == REG_TAP_COUNT)) begin
      tap_count_q <= pwdata[TAP_COUNT_W-1:0];
    end
  end

  // taps in use, centre offset and first flushed position for this sample
  always_comb begin
    if (tap_count_q == '0) begin
      n_use = N_W'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      n_use = N_W'(MAX_TAPS);
    end else begin
      n_use = N_W'(tap_count_q);
    end
    s_use    = (n_use - N_W'(1)) >> 1;
    emit_now = 32'(row_cnt_q) >= 32'(s_use);
    if (emit_now) begin
      first_use = N_W'(1);
    end else begin
      first_use = N_W'(32'(s_use) - 32'(row_cnt_q));
    end
    e_nxt = e_q + N_W'(1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          if (emit_now) begin
            state_d = ST_LOAD;
          end else if (in_data_i.row_last) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_LOAD: state_d = ST_MAC;
      ST_MAC: begin
        if (cnt_q == n_q - N_W'(1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = (last_q && (e_q != s_q)) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (e_nxt >= first_q) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_cnt_q <= '0;
      n_q       <= N_W'(1);
      s_q       <= '0;
      e_q       <= '0;
      first_q   <= N_W'(1);
      cnt_q     <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (smp_acc) begin
        n_q     <= n_use;
        s_q     <= s_use;
        first_q <= first_use;
        e_q     <= '0;
        last_q  <= in_data_i.row_last;
        if (in_data_i.row_last) begin
          row_cnt_q <= '0;
        end else if (row_cnt_q != ROW_COUNT_MAX) begin
          row_cnt_q <= row_cnt_q + ROW_COUNT_W'(1);
        end
      end
      if (state_q == ST_FLUSH) begin
        e_q <= e_nxt;
      end
      if (state_q == ST_LOAD) begin
        cnt_q <= '0;
      end else if (state_q == ST_MAC) begin
        cnt_q <= cnt_q + N_W'(1);
      end
    end
  end

  // flush positions shift zeros in behind the row
  assign cell_ctrl.hist_shift = smp_acc || (state_q == ST_FLUSH);
  assign cell_ctrl.hist_clear = row_done;
  assign cell_ctrl.scan_load  = (state_q == ST_LOAD);
  assign cell_ctrl.scan_shift = (state_q == ST_MAC);
  assign mac_ctrl.acc_clear   = (state_q == ST_LOAD);
  assign mac_ctrl.mul_en      = (state_q == ST_MAC);

  assign hist_w[0]        = smp_acc ? in_data_i.sample : '0;
  assign stap_w[MAX_TAPS] = '0;
  assign ssmp_w[MAX_TAPS] = '0;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    assign tap_we[k] = tap_acc && (32'(in_data_i.tap_index) == k);

    rfc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .tap_we_i   (tap_we[k]),
      .tap_i      (in_data_i.tap_value),
      .hist_i     (hist_w[k]),
      .scan_tap_i (stap_w[k+1]),
      .scan_smp_i (ssmp_w[k+1]),
      .hist_o     (hist_w[k+1]),
      .scan_tap_o (stap_w[k]),
      .scan_smp_o (ssmp_w[k])
    );
  end

  rfc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .tap_i   ($signed(stap_w[0])),
    .smp_i   ($signed(ssmp_w[0])),
    .value_o (mac_value)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_data_q.value <= mac_value;
      out_data_q.last  <= last_q && (e_q == s_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_emit_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> out_valid_o)
    else $error("finished result not presented");

  a_flush_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_q <= s_q)
    else $error("flush position past centre offset");

  a_mac_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (cnt_q < n_q))
    else $error("tap walk past taps in use");

  a_row_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_done |=> (in_ready_o && (row_cnt_q == '0)))
    else $error("row end did not return to idle");
`endif

endmodule

// ===== design/rfc_cell.sv =====
`timescale 1ns / 1ps
module rfc_cell import rfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic                tap_we_i,
  input  logic [SAMPLE_W-1:0] tap_i,
  input  logic [SAMPLE_W-1:0] hist_i,
  input  logic [SAMPLE_W-1:0] scan_tap_i,
  input  logic [SAMPLE_W-1:0] scan_smp_i,
  output logic [SAMPLE_W-1:0] hist_o,
  output logic [SAMPLE_W-1:0] scan_tap_o,
  output logic [SAMPLE_W-1:0] scan_smp_o
);

  logic [SAMPLE_W-1:0] tap_q;
  logic [SAMPLE_W-1:0] hist_q;
  logic [SAMPLE_W-1:0] scan_tap_q;
  logic [SAMPLE_W-1:0] scan_smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= '0;
      hist_q <= '0;
    end else begin
      if (tap_we_i) begin
        tap_q <= tap_i;
      end
      if (ctrl_i.hist_clear) begin
        hist_q <= '0;
      end else if (ctrl_i.hist_shift) begin
        hist_q <= hist_i;
      end
    end
  end

  // scan copy walks towards the head of the chain, one cell a cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_load) begin
      scan_tap_q <= tap_q;
      scan_smp_q <= hist_q;
    end else if (ctrl_i.scan_shift) begin
      scan_tap_q <= scan_tap_i;
      scan_smp_q <= scan_smp_i;
    end
  end

  assign hist_o     = hist_q;
  assign scan_tap_o = scan_tap_q;
  assign scan_smp_o = scan_smp_q;

endmodule

// ===== design/rfc_mac.sv =====
`timescale 1ns / 1ps
module rfc_mac import rfc_pkg::*; #(
  parameter int unsigned ACC_W = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [SAMPLE_W-1:0] tap_i,
  input  logic signed [SAMPLE_W-1:0] smp_i,
  output logic signed [SAMPLE_W-1:0] value_o
);

  localparam int unsigned PROD_W = 2 * SAMPLE_W;
  localparam int unsigned QUO_W  = ACC_W - ROUND_SHIFT;

  localparam logic signed [ACC_W-1:0]    RoundHalf = ACC_W'(2 ** (ROUND_SHIFT - 1));
  localparam logic signed [SAMPLE_W-1:0] OutMax    = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] OutMin    = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [QUO_W-1:0]    QuoMax    = QUO_W'(OutMax);
  localparam logic signed [QUO_W-1:0]    QuoMin    = QUO_W'(OutMin);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [QUO_W-1:0]  quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(tap_i) * PROD_W'(smp_i);
    end
    if (ctrl_i.acc_clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, floor shift, then clamp to the sample range
  always_comb begin
    rnd = acc_q + RoundHalf;
    quo = $signed(rnd[ACC_W-1:ROUND_SHIFT]);
    if (quo > QuoMax) begin
      value_o = OutMax;
    end else if (quo < QuoMin) begin
      value_o = OutMin;
    end else begin
      value_o = $signed(quo[SAMPLE_W-1:0]);
    end
  end

endmodule
